// ===== hdl/tof_zone_to_xyz_defines.svh =====
// Assertion macros shared by the tof_zone_to_xyz modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TOF_ZONE_TO_XYZ_DEFINES_SVH
`define TOF_ZONE_TO_XYZ_DEFINES_SVH

`ifndef SYNTHESIS
`define TZX_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`define TZX_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define TZX_ASSERT_IMPLY(lbl, cond, prop, msg)
`define TZX_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// ===== hdl/tzx_pkg.sv =====
package tzx_pkg;

  localparam int ZONE_COUNT = 64;
  localparam int ROM_DEPTH  = 64;
  localparam int ZONE_W     = 6;
  localparam int DIST_W     = 13;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = DIST_W + COEF_W;
  localparam int FRAC_W     = 14;

  localparam logic [1:0] MNT_FWD   = 2'd0;
  localparam logic [1:0] MNT_LEFT  = 2'd1;
  localparam logic [1:0] MNT_RIGHT = 2'd2;
  localparam logic [1:0] MNT_SPARE = 2'd3;

  localparam logic [7:0] STATUS_OK_A = 8'd5;
  localparam logic [7:0] STATUS_OK_B = 8'd6;
  localparam logic [7:0] STATUS_OK_C = 8'd9;

  // Per-zone coefficients in signed Q2.14.
  localparam logic signed [COEF_W-1:0] COEF_X [ROM_DEPTH] = '{
    -16'sd6961, -16'sd4629, -16'sd2673, -16'sd843, 16'sd843, 16'sd2673, 16'sd4629, 16'sd6961,
    -16'sd6514, -16'sd4217, -16'sd2593, -16'sd867, 16'sd867, 16'sd2593, 16'sd4217, 16'sd6514,
    -16'sd6238, -16'sd4322, -16'sd2590, -16'sd868, 16'sd868, 16'sd2590, 16'sd4322, 16'sd6238,
    -16'sd5903, -16'sd4335, -16'sd2601, -16'sd861, 16'sd861, 16'sd2601, 16'sd4335, 16'sd5903,
    -16'sd5903, -16'sd4335, -16'sd2601, -16'sd861, 16'sd861, 16'sd2601, 16'sd4335, 16'sd5903,
    -16'sd6238, -16'sd4322, -16'sd2590, -16'sd868, 16'sd868, 16'sd2590, 16'sd4322, 16'sd6238,
    -16'sd7345, -16'sd4217, -16'sd2593, -16'sd867, 16'sd867, 16'sd2593, 16'sd4217, 16'sd6514,
    -16'sd6961, -16'sd4629, -16'sd2673, -16'sd843, 16'sd843, 16'sd2673, 16'sd4629, 16'sd6961
  };

  localparam logic signed [COEF_W-1:0] COEF_Y [ROM_DEPTH] = '{
    16'sd6961, 16'sd6514, 16'sd6238, 16'sd5903, 16'sd5903, 16'sd6238, 16'sd6514, 16'sd6961,
    16'sd4629, 16'sd4217, 16'sd4322, 16'sd4335, 16'sd4335, 16'sd4322, 16'sd4217, 16'sd4629,
    16'sd2673, 16'sd2593, 16'sd2590, 16'sd2601, 16'sd2601, 16'sd2590, 16'sd2593, 16'sd2673,
    16'sd843, 16'sd867, 16'sd868, 16'sd861, 16'sd861, 16'sd868, 16'sd867, 16'sd843,
    -16'sd843, -16'sd867, -16'sd868, -16'sd861, -16'sd861, -16'sd868, -16'sd867, -16'sd843,
    -16'sd2673, -16'sd2593, -16'sd2590, -16'sd2601, -16'sd2601, -16'sd2590, -16'sd2593, -16'sd2673,
    -16'sd3148, -16'sd4217, -16'sd4322, -16'sd4335, -16'sd4335, -16'sd4322, -16'sd4217, -16'sd4629,
    -16'sd6961, -16'sd6514, -16'sd6238, -16'sd5903, -16'sd5903, -16'sd6238, -16'sd6514, -16'sd6961
  };

  typedef struct packed {
    logic                     ok;
    logic [1:0]               mount;
    logic signed [DIST_W-1:0] d;
    logic signed [COEF_W-1:0] kx;
    logic signed [COEF_W-1:0] ky;
  } lookup_t;

  typedef struct packed {
    logic                     ok;
    logic [1:0]               mount;
    logic signed [DIST_W-1:0] d;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
  } prod_t;

  typedef struct packed {
    logic                     ok;
    logic [1:0]               mount;
    logic signed [DIST_W-1:0] d;
    logic signed [DIST_W-1:0] x;
    logic signed [DIST_W-1:0] y;
  } coord_t;

  // Drops the Q2.14 fraction, rounding to nearest with ties away from zero.
  function automatic logic signed [DIST_W-1:0] round_q14(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [DIST_W-1:0] r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    sum = mag + PROD_W'(1 << (FRAC_W - 1));
    r   = sum[FRAC_W +: DIST_W];
    return p[PROD_W-1] ? DIST_W'(-$signed(r)) : $signed(r);
  endfunction

endpackage

// ===== hdl/tzx_decode.sv =====
module tzx_decode (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  output logic                   in_rdy,
  input  logic [31:0]            in_data,
  output logic                   out_vld,
  input  logic                   out_rdy,
  output tzx_pkg::lookup_t       out_data
);

  logic [tzx_pkg::ZONE_W-1:0]         zone;
  logic signed [tzx_pkg::DIST_W-1:0]  dist_mm;
  logic [2:0]                         count;
  logic [7:0]                         status;
  logic [1:0]                         mount;
  logic                               ok;
  logic                               vld_r;
  tzx_pkg::lookup_t                   data_r;
  tzx_pkg::lookup_t                   data_nxt;

  assign zone    = in_data[5:0];
  assign dist_mm = $signed(in_data[18:6]);
  assign count   = in_data[21:19];
  assign status  = in_data[29:22];
  assign mount   = in_data[31:30];

  assign ok = ({1'b0, zone} < (tzx_pkg::ZONE_W + 1)'(tzx_pkg::ZONE_COUNT)) &&
              (count != 3'd0) && !dist_mm[tzx_pkg::DIST_W-1] && (dist_mm != '0) &&
              (status == tzx_pkg::STATUS_OK_A || status == tzx_pkg::STATUS_OK_B ||
               status == tzx_pkg::STATUS_OK_C);

  // An invalid zone carries a zero distance, so everything downstream comes out zero.
  always_comb begin
    data_nxt.ok    = ok;
    data_nxt.mount = mount;
    data_nxt.d     = ok ? dist_mm : '0;
    data_nxt.kx    = tzx_pkg::COEF_X[zone];
    data_nxt.ky    = tzx_pkg::COEF_Y[zone];
  end

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== hdl/tzx_scale.sv =====
module tzx_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  tzx_pkg::lookup_t  in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output tzx_pkg::coord_t   out_data
);

  logic             prod_vld_r;
  logic             prod_rdy;
  tzx_pkg::prod_t   prod_r;
  tzx_pkg::prod_t   prod_nxt;
  logic             rnd_vld_r;
  tzx_pkg::coord_t  rnd_r;
  tzx_pkg::coord_t  rnd_nxt;

  // Multiply stage.
  always_comb begin
    prod_nxt.ok    = in_data.ok;
    prod_nxt.mount = in_data.mount;
    prod_nxt.d     = in_data.d;
    prod_nxt.px    = tzx_pkg::PROD_W'(in_data.d) * tzx_pkg::PROD_W'(in_data.kx);
    prod_nxt.py    = tzx_pkg::PROD_W'(in_data.d) * tzx_pkg::PROD_W'(in_data.ky);
  end

  // Rounding stage.
  always_comb begin
    rnd_nxt.ok    = prod_r.ok;
    rnd_nxt.mount = prod_r.mount;
    rnd_nxt.d     = prod_r.d;
    rnd_nxt.x     = tzx_pkg::round_q14(prod_r.px);
    rnd_nxt.y     = tzx_pkg::round_q14(prod_r.py);
  end

  assign prod_rdy = !rnd_vld_r || out_rdy;
  assign in_rdy   = !prod_vld_r || prod_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      rnd_vld_r  <= 1'b0;
    end else begin
      if (in_rdy) begin
        prod_vld_r <= in_vld;
      end
      if (prod_rdy) begin
        rnd_vld_r <= prod_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      prod_r <= prod_nxt;
    end
    if (prod_rdy && prod_vld_r) begin
      rnd_r <= rnd_nxt;
    end
  end

  assign out_vld  = rnd_vld_r;
  assign out_data = rnd_r;

endmodule

// ===== hdl/tzx_rotate.sv =====
`include "tof_zone_to_xyz_defines.svh"

module tzx_rotate (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  output logic                              in_rdy,
  input  tzx_pkg::coord_t                   in_data,
  output logic                              out_vld,
  input  logic                              out_rdy,
  output logic signed [tzx_pkg::DIST_W-1:0] out_x,
  output logic signed [tzx_pkg::DIST_W-1:0] out_y,
  output logic signed [tzx_pkg::DIST_W-1:0] out_z,
  output logic                              out_ok
);

  logic                               vld_r;
  logic                               take;
  logic signed [tzx_pkg::DIST_W-1:0]  x_r;
  logic signed [tzx_pkg::DIST_W-1:0]  y_r;
  logic signed [tzx_pkg::DIST_W-1:0]  z_r;
  logic                               ok_r;
  logic signed [tzx_pkg::DIST_W-1:0]  x_nxt;
  logic signed [tzx_pkg::DIST_W-1:0]  z_nxt;

  // The unused mounting code falls back to the forward orientation.
  always_comb begin
    case (in_data.mount)
      tzx_pkg::MNT_LEFT: begin
        x_nxt = -in_data.d;
        z_nxt = in_data.x;
      end
      tzx_pkg::MNT_RIGHT: begin
        x_nxt = in_data.d;
        z_nxt = -in_data.x;
      end
      default: begin
        x_nxt = in_data.x;
        z_nxt = in_data.d;
      end
    endcase
  end

  assign in_rdy = !vld_r || out_rdy;
  assign take   = in_rdy && in_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r  <= x_nxt;
      y_r  <= in_data.y;
      z_r  <= z_nxt;
      ok_r <= in_data.ok;
    end
  end

  assign out_vld = vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_ok  = ok_r;

  `TZX_ASSERT_NEXT(a_left_x_neg, take && in_data.ok && in_data.mount == tzx_pkg::MNT_LEFT, x_r[tzx_pkg::DIST_W-1], "left mounting must give a negative x")
  `TZX_ASSERT_NEXT(a_right_x_pos, take && in_data.ok && in_data.mount == tzx_pkg::MNT_RIGHT, !x_r[tzx_pkg::DIST_W-1] && x_r != '0, "right mounting must give a positive x")
  `TZX_ASSERT_IMPLY(a_invalid_zero, vld_r && !ok_r, x_r == '0 && y_r == '0 && z_r == '0, "invalid zone must give zero coordinates")

endmodule

// ===== hdl/tof_zone_to_xyz.sv =====
// Pipeline: four register stages (lookup, multiply, round, rotate), each registering its
// result in that order on the way from an accepted zone to its output.
// Throughput: one zone per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles are squeezed out under back-pressure.
// Reset: synchronous, active low; clears the stage valid bits only, the data registers are not reset.
module tof_zone_to_xyz (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // zone_index, distance, target_count, status_code, mounting
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // x_mm, y_mm, z_mm, zero pad
  output logic        out_tuser   // zone_valid
);

  logic                               lk_vld;
  logic                               lk_rdy;
  tzx_pkg::lookup_t                   lk_data;
  logic                               sc_vld;
  logic                               sc_rdy;
  tzx_pkg::coord_t                    sc_data;
  logic signed [tzx_pkg::DIST_W-1:0]  x_mm;
  logic signed [tzx_pkg::DIST_W-1:0]  y_mm;
  logic signed [tzx_pkg::DIST_W-1:0]  z_mm;

  tzx_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_data  (in_tdata),
    .out_vld  (lk_vld),
    .out_rdy  (lk_rdy),
    .out_data (lk_data)
  );

  tzx_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (lk_vld),
    .in_rdy   (lk_rdy),
    .in_data  (lk_data),
    .out_vld  (sc_vld),
    .out_rdy  (sc_rdy),
    .out_data (sc_data)
  );

  tzx_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_vld),
    .in_rdy  (sc_rdy),
    .in_data (sc_data),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_x   (x_mm),
    .out_y   (y_mm),
    .out_z   (z_mm),
    .out_ok  (out_tuser)
  );

  assign out_tdata = {1'b0, z_mm, y_mm, x_mm};

endmodule

// ===== bench/tb_tof_zone_to_xyz.sv =====
module tb_tof_zone_to_xyz;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;

  // Per-zone Q2.14 gains, kept here independently of the block's ROM.
  localparam int KX [64] = '{
    -6961, -4629, -2673,  -843,   843,  2673,  4629,  6961,
    -6514, -4217, -2593,  -867,   867,  2593,  4217,  6514,
    -6238, -4322, -2590,  -868,   868,  2590,  4322,  6238,
    -5903, -4335, -2601,  -861,   861,  2601,  4335,  5903,
    -5903, -4335, -2601,  -861,   861,  2601,  4335,  5903,
    -6238, -4322, -2590,  -868,   868,  2590,  4322,  6238,
    -7345, -4217, -2593,  -867,   867,  2593,  4217,  6514,
    -6961, -4629, -2673,  -843,   843,  2673,  4629,  6961
  };

  localparam int KY [64] = '{
     6961,  6514,  6238,  5903,  5903,  6238,  6514,  6961,
     4629,  4217,  4322,  4335,  4335,  4322,  4217,  4629,
     2673,  2593,  2590,  2601,  2601,  2590,  2593,  2673,
      843,   867,   868,   861,   861,   868,   867,   843,
     -843,  -867,  -868,  -861,  -861,  -868,  -867,  -843,
    -2673, -2593, -2590, -2601, -2601, -2590, -2593, -2673,
    -3148, -4217, -4322, -4335, -4335, -4322, -4217, -4629,
    -6961, -6514, -6238, -5903, -5903, -6238, -6514, -6961
  };

  typedef struct packed {
    logic [1:0]                        mount;
    logic [7:0]                        status;
    logic [2:0]                        count;
    logic signed [tzx_pkg::DIST_W-1:0] dist_mm;
    logic [tzx_pkg::ZONE_W-1:0]        zone;
  } zone_rec_t;

  typedef struct packed {
    logic                              valid;
    logic signed [tzx_pkg::DIST_W-1:0] z;
    logic signed [tzx_pkg::DIST_W-1:0] y;
    logic signed [tzx_pkg::DIST_W-1:0] x;
  } xyz_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  xyz_rec_t pending_xyz[$];
  int       mismatch_cnt = 0;
  int       tx_max_gap = 0;
  int       rx_max_stall = 0;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       stall_left = 0;
  int       stall_next;
  int       idle_cycles = 0;
  xyz_rec_t got, want;

  tof_zone_to_xyz dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Scales a distance by a Q2.14 gain, rounding to nearest with ties away from zero.
  function automatic int q14_scale(int d, int k);
    int p;
    int mag;
    int r;
    p = d * k;
    mag = (p < 0) ? -p : p;
    r = (mag + 8192) >>> 14;
    return (p < 0) ? -r : r;
  endfunction

  function automatic xyz_rec_t zone_to_xyz(zone_rec_t zr);
    xyz_rec_t r;
    int d, x, y, rx, ry, rz;
    bit ok;
    r = '0;
    d = zr.dist_mm;
    ok = (int'(zr.zone) < tzx_pkg::ZONE_COUNT) && (zr.count != 0) && (d > 0) &&
         (zr.status == tzx_pkg::STATUS_OK_A || zr.status == tzx_pkg::STATUS_OK_B ||
          zr.status == tzx_pkg::STATUS_OK_C);
    if (ok) begin
      x = q14_scale(d, KX[zr.zone]);
      y = q14_scale(d, KY[zr.zone]);
      case (zr.mount)
        tzx_pkg::MNT_LEFT: begin
          rx = -d; ry = y; rz = x;
        end
        tzx_pkg::MNT_RIGHT: begin
          rx = d; ry = y; rz = -x;
        end
        default: begin
          rx = x; ry = y; rz = d;
        end
      endcase
      r.x = rx[tzx_pkg::DIST_W-1:0];
      r.y = ry[tzx_pkg::DIST_W-1:0];
      r.z = rz[tzx_pkg::DIST_W-1:0];
      r.valid = 1'b1;
    end
    return r;
  endfunction

  function automatic zone_rec_t mk_zone(int zone, int dist_mm, int count, int status, int mount);
    zone_rec_t zr;
    zr.zone = zone[tzx_pkg::ZONE_W-1:0];
    zr.dist_mm = dist_mm[tzx_pkg::DIST_W-1:0];
    zr.count = count[2:0];
    zr.status = status[7:0];
    zr.mount = mount[1:0];
    return zr;
  endfunction

  // Mostly zones that pass the check, with random geometry; the rest is raw noise.
  function automatic zone_rec_t rand_zone();
    zone_rec_t zr;
    logic [7:0] good_codes [3];
    good_codes = '{tzx_pkg::STATUS_OK_A, tzx_pkg::STATUS_OK_B, tzx_pkg::STATUS_OK_C};
    zr = zone_rec_t'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      zr.status = good_codes[$urandom_range(0, 2)];
      zr.count = 3'($urandom_range(1, 4));
      zr.dist_mm = ($urandom_range(0, 3) == 0) ? tzx_pkg::DIST_W'($urandom_range(1, 255)) :
                                                 tzx_pkg::DIST_W'($urandom_range(1, 4095));
      zr.mount = ($urandom_range(0, 9) == 0) ? tzx_pkg::MNT_SPARE : 2'($urandom_range(0, 2));
    end
    return zr;
  endfunction

  task automatic send_zone(zone_rec_t zr);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= zr;
    do @(posedge clk); while (!in_tready);
    pending_xyz.push_back(zone_to_xyz(zr));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_xyz.size() != 0) @(posedge clk);
  endtask

  task automatic test_distance_extremes();
    send_zone(mk_zone(0, 4095, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(63, 4095, 4, tzx_pkg::STATUS_OK_C, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(7, 1, 1, tzx_pkg::STATUS_OK_B, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(56, 0, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(9, -1, 2, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(48, -4096, 3, tzx_pkg::STATUS_OK_B, tzx_pkg::MNT_FWD));
    wait_drain();
  endtask

  task automatic test_status_codes();
    int codes [7] = '{0, 4, 5, 6, 7, 9, 255};
    foreach (codes[i]) send_zone(mk_zone(20 + i, 1500, 1, codes[i], tzx_pkg::MNT_FWD));
    wait_drain();
  endtask

  task automatic test_target_count();
    int counts [4] = '{0, 1, 4, 7};
    foreach (counts[i]) begin
      send_zone(mk_zone(33, 3000, counts[i], tzx_pkg::STATUS_OK_C, tzx_pkg::MNT_FWD));
    end
    wait_drain();
  endtask

  task automatic test_mountings();
    // The spare code is unused and must behave like forward.
    send_zone(mk_zone(48, 4095, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(48, 4095, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_LEFT));
    send_zone(mk_zone(48, 4095, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_RIGHT));
    send_zone(mk_zone(48, 4095, 1, tzx_pkg::STATUS_OK_A, tzx_pkg::MNT_SPARE));
    wait_drain();
  endtask

  task automatic test_rounding_ties();
    // Each zone has one product that lands exactly halfway between two millimetres.
    send_zone(mk_zone(48, 2048, 1, tzx_pkg::STATUS_OK_B, tzx_pkg::MNT_FWD));
    send_zone(mk_zone(19, 2048, 1, tzx_pkg::STATUS_OK_B, tzx_pkg::MNT_FWD));
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_max_gap = 0;
    rx_max_stall = 0;
    hold_req = hold_req + 1;
    repeat (40) send_zone(rand_zone());
    wait_drain();
  endtask

  task automatic test_random();
    int gaps [4] = '{14, 0, 14, 0};
    int stalls [4] = '{14, 0, 0, 14};
    foreach (gaps[s]) begin
      tx_max_gap = gaps[s];
      rx_max_stall = stalls[s];
      repeat (275) send_zone(rand_zone());
      wait_drain();
    end
  endtask

  // Result side: random stalls per transaction, long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      stall_next = stall_left;
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[12:0];
        got.y = out_tdata[25:13];
        got.z = out_tdata[38:26];
        got.valid = out_tuser;
        if (pending_xyz.size() == 0) begin
          $error("unexpected result: x_mm %0d y_mm %0d z_mm %0d zone_valid %0b",
                 got.x, got.y, got.z, got.valid);
          mismatch_cnt++;
        end else begin
          want = pending_xyz.pop_front();
          if (got.x !== want.x) begin
            $error("x_mm: expected %0d, actual %0d", want.x, got.x);
            mismatch_cnt++;
          end
          if (got.y !== want.y) begin
            $error("y_mm: expected %0d, actual %0d", want.y, got.y);
            mismatch_cnt++;
          end
          if (got.z !== want.z) begin
            $error("z_mm: expected %0d, actual %0d", want.z, got.z);
            mismatch_cnt++;
          end
          if (got.valid !== want.valid) begin
            $error("zone_valid: expected %0b, actual %0b", want.valid, got.valid);
            mismatch_cnt++;
          end
        end
        stall_next = $urandom_range(0, rx_max_stall);
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_next > 0) begin
        stall_left = stall_next - 1;
        out_tready <= 1'b0;
      end else begin
        stall_left = 0;
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_distance_extremes();
    test_status_codes();
    test_target_count();
    test_mountings();
    test_rounding_ties();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_xyz.size() != 0) begin
      $error("%0d expected results never arrived", pending_xyz.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
